FILE: rtl/core/ctiu_pkg.sv
// ----------------------------------------------------------------------------
// ctiu_pkg
// Shared codes and constants of the timer, time-of-day and interrupt unit.
// ----------------------------------------------------------------------------
package ctiu_pkg;

    // command codes
    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_WRITE    = 3'd1;
    localparam logic [2:0] CMD_TIMER    = 3'd2;
    localparam logic [2:0] CMD_TOD      = 3'd3;
    localparam logic [2:0] CMD_FLAG     = 3'd4;

    // register map
    localparam logic [3:0] REG_PORT_A   = 4'd0;
    localparam logic [3:0] REG_PORT_B   = 4'd1;
    localparam logic [3:0] REG_DDR_A    = 4'd2;
    localparam logic [3:0] REG_DDR_B    = 4'd3;
    localparam logic [3:0] REG_TA_LO    = 4'd4;
    localparam logic [3:0] REG_TA_HI    = 4'd5;
    localparam logic [3:0] REG_TB_LO    = 4'd6;
    localparam logic [3:0] REG_TB_HI    = 4'd7;
    localparam logic [3:0] REG_TOD_LO   = 4'd8;
    localparam logic [3:0] REG_TOD_MID  = 4'd9;
    localparam logic [3:0] REG_TOD_HI   = 4'd10;
    localparam logic [3:0] REG_SERIAL   = 4'd12;
    localparam logic [3:0] REG_ICR      = 4'd13;
    localparam logic [3:0] REG_CRA      = 4'd14;
    localparam logic [3:0] REG_CRB      = 4'd15;

    // control register fields
    localparam logic [7:0] TIMER_A_RUN_MASK  = 8'h21;
    localparam logic [7:0] TIMER_B_MODE_MASK = 8'h61;
    localparam logic [7:0] TIMER_B_CASCADE   = 8'h41;
    localparam logic [7:0] TIMER_RUN_CODE    = 8'h01;
    localparam logic [7:0] FORCE_LOAD_BIT    = 8'h10;
    localparam int         CTRL_START        = 0;
    localparam int         CTRL_ONESHOT      = 3;
    localparam int         CTRL_ALARM        = 7;
    localparam int         MASK_SET          = 7;

    // interrupt source bits
    localparam int         SRC_TIMER_A       = 0;
    localparam int         SRC_TIMER_B       = 1;
    localparam int         SRC_ALARM         = 2;
    localparam int         SRC_FLAG          = 4;

    // reset values
    localparam logic [15:0] WORD_RESET       = 16'hFFFF;
    localparam logic [7:0]  CTRL_RESET       = 8'h04;
    localparam logic [7:0]  PORT_A_RESET     = 8'h8C;
    localparam logic [7:0]  PORT_A_READ_OR   = 8'h03;

endpackage

FILE: rtl/core/cia_timer_tod_interrupt_unit_top.sv
// ----------------------------------------------------------------------------
// cia_timer_tod_interrupt_unit_top
// Bus registers, two interval timers, time-of-day clock and interrupt control.
// ----------------------------------------------------------------------------
// an accepted word is registered into the result register, or into the skid when the result register is held
// throughput: one word per cycle while in_stall is low; state updates in one pass at the accept edge
// a two-entry output stage (result register plus skid) parts the channels,
// in_stall rises only when both entries hold words
// reset: asynchronous for state and valid registers; output data and irq registers have no reset
module cia_timer_tod_interrupt_unit_top
    import ctiu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] command,
    input  logic [3:0] reg_addr,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       irq
);

    logic [15:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [15:0] reload_a_reg, reload_a_next, reload_b_reg, reload_b_next;
    logic [7:0]  ctrl_a_reg, ctrl_a_next, ctrl_b_reg, ctrl_b_next;
    logic [23:0] day_reg, day_next, alarm_reg, alarm_next, snap_reg, snap_next;
    logic        snap_held_reg, snap_held_next, running_reg, running_next;
    logic [4:0]  pending_reg, pending_next;
    logic [6:0]  mask_reg, mask_next;
    logic [7:0]  port_a_reg, port_a_next, port_b_reg, port_b_next;
    logic [7:0]  ddr_a_reg, ddr_a_next, ddr_b_reg, ddr_b_next;
    logic [7:0]  serial_reg, serial_next;

    logic        out_valid_reg, skid_valid_reg;
    logic [7:0]  out_data_reg, skid_data_reg;
    logic        out_irq_reg, skid_irq_reg;

    logic        accept, out_fire;
    logic        run_a, run_b, casc_b, step_b, under_a, under_b;
    logic        irq_cur, irq_new;
    logic [7:0]  rd_new;
    logic [15:0] cnt_a_dec, cnt_b_dec;
    logic [23:0] tod_view, day_inc;

    assign accept   = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign run_a   = (ctrl_a_reg & TIMER_A_RUN_MASK) == TIMER_RUN_CODE;
    assign run_b   = (ctrl_b_reg & TIMER_B_MODE_MASK) == TIMER_RUN_CODE;
    assign casc_b  = (ctrl_b_reg & TIMER_B_MODE_MASK) == TIMER_B_CASCADE;
    assign under_a = run_a && (cnt_a_reg == 16'd0);
    assign step_b  = run_b || (casc_b && under_a);
    assign under_b = step_b && (cnt_b_reg == 16'd0);
    assign cnt_a_dec = cnt_a_reg - 16'd1;
    assign cnt_b_dec = cnt_b_reg - 16'd1;

    assign tod_view = snap_held_reg ? snap_reg : day_reg;
    assign day_inc  = running_reg ? (day_reg + 24'd1) : day_reg;
    assign irq_cur  = |(pending_reg & mask_reg[4:0]);

    always_comb
    begin
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        reload_a_next  = reload_a_reg;
        reload_b_next  = reload_b_reg;
        ctrl_a_next    = ctrl_a_reg;
        ctrl_b_next    = ctrl_b_reg;
        day_next       = day_reg;
        alarm_next     = alarm_reg;
        snap_next      = snap_reg;
        snap_held_next = snap_held_reg;
        running_next   = running_reg;
        pending_next   = pending_reg;
        mask_next      = mask_reg;
        port_a_next    = port_a_reg;
        port_b_next    = port_b_reg;
        ddr_a_next     = ddr_a_reg;
        ddr_b_next     = ddr_b_reg;
        serial_next    = serial_reg;
        rd_new         = 8'd0;

        if (accept)
        begin
            case (command)
                CMD_READ:
                begin
                    unique case (reg_addr)
                        REG_PORT_A:  rd_new = port_a_reg | PORT_A_READ_OR;
                        REG_PORT_B:  rd_new = port_b_reg;
                        REG_DDR_A:   rd_new = ddr_a_reg;
                        REG_DDR_B:   rd_new = ddr_b_reg;
                        REG_TA_LO:   rd_new = cnt_a_reg[7:0];
                        REG_TA_HI:   rd_new = cnt_a_reg[15:8];
                        REG_TB_LO:   rd_new = cnt_b_reg[7:0];
                        REG_TB_HI:   rd_new = cnt_b_reg[15:8];
                        REG_TOD_LO:
                        begin
                            rd_new         = tod_view[7:0];
                            snap_held_next = 1'b0;
                        end
                        REG_TOD_MID: rd_new = tod_view[15:8];
                        REG_TOD_HI:
                        begin
                            // snapshot the clock for the following mid/low reads
                            rd_new         = day_reg[23:16];
                            snap_next      = day_reg;
                            snap_held_next = 1'b1;
                        end
                        REG_SERIAL:  rd_new = serial_reg;
                        REG_ICR:
                        begin
                            rd_new       = {irq_cur, 2'b00, pending_reg};
                            pending_next = 5'd0;
                        end
                        REG_CRA:     rd_new = ctrl_a_reg;
                        REG_CRB:     rd_new = ctrl_b_reg;
                        default:     rd_new = 8'd0;
                    endcase
                end
                CMD_WRITE:
                begin
                    unique case (reg_addr)
                        REG_PORT_A:  port_a_next = write_data;
                        REG_PORT_B:  port_b_next = write_data;
                        REG_DDR_A:   ddr_a_next  = write_data;
                        REG_DDR_B:   ddr_b_next  = write_data;
                        REG_TA_LO:   reload_a_next = {reload_a_reg[15:8], write_data};
                        REG_TA_HI:
                        begin
                            reload_a_next = {write_data, reload_a_reg[7:0]};
                            if (!ctrl_a_reg[CTRL_START] || ctrl_a_reg[CTRL_ONESHOT])
                                cnt_a_next = {write_data, reload_a_reg[7:0]};
                            if (ctrl_a_reg[CTRL_ONESHOT])
                                ctrl_a_next[CTRL_START] = 1'b1;
                        end
                        REG_TB_LO:   reload_b_next = {reload_b_reg[15:8], write_data};
                        REG_TB_HI:
                        begin
                            reload_b_next = {write_data, reload_b_reg[7:0]};
                            if (!ctrl_b_reg[CTRL_START] || ctrl_b_reg[CTRL_ONESHOT])
                                cnt_b_next = {write_data, reload_b_reg[7:0]};
                            if (ctrl_b_reg[CTRL_ONESHOT])
                                ctrl_b_next[CTRL_START] = 1'b1;
                        end
                        REG_TOD_LO:
                        begin
                            if (ctrl_b_reg[CTRL_ALARM])
                                alarm_next[7:0] = write_data;
                            else
                            begin
                                day_next[7:0] = write_data;
                                running_next  = 1'b1;
                            end
                        end
                        REG_TOD_MID:
                        begin
                            if (ctrl_b_reg[CTRL_ALARM])
                                alarm_next[15:8] = write_data;
                            else
                            begin
                                day_next[15:8] = write_data;
                                running_next   = 1'b0;
                            end
                        end
                        REG_TOD_HI:
                        begin
                            if (ctrl_b_reg[CTRL_ALARM])
                                alarm_next[23:16] = write_data;
                            else
                            begin
                                day_next[23:16] = write_data;
                                running_next    = 1'b0;
                            end
                        end
                        REG_SERIAL:  serial_next = write_data;
                        REG_ICR:
                        begin
                            if (write_data[MASK_SET])
                                mask_next = mask_reg | write_data[6:0];
                            else
                                mask_next = mask_reg & ~write_data[6:0];
                        end
                        REG_CRA:
                        begin
                            ctrl_a_next = write_data & ~FORCE_LOAD_BIT;
                            if ((write_data & FORCE_LOAD_BIT) != 8'd0)
                                cnt_a_next = reload_a_reg;
                        end
                        REG_CRB:
                        begin
                            ctrl_b_next = write_data & ~FORCE_LOAD_BIT;
                            if ((write_data & FORCE_LOAD_BIT) != 8'd0)
                                cnt_b_next = reload_b_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_TIMER:
                begin
                    if (run_a)
                        cnt_a_next = cnt_a_dec;
                    if (step_b)
                        cnt_b_next = cnt_b_dec;
                    if (under_a)
                    begin
                        pending_next[SRC_TIMER_A] = 1'b1;
                        cnt_a_next = reload_a_reg;
                        if (ctrl_a_reg[CTRL_ONESHOT])
                            ctrl_a_next[CTRL_START] = 1'b0;
                    end
                    if (under_b)
                    begin
                        pending_next[SRC_TIMER_B] = 1'b1;
                        cnt_b_next = reload_b_reg;
                        if (ctrl_b_reg[CTRL_ONESHOT])
                            ctrl_b_next[CTRL_START] = 1'b0;
                    end
                end
                CMD_TOD:
                begin
                    // alarm compare runs even while the clock is stopped
                    day_next = day_inc;
                    if (day_inc == alarm_reg)
                        pending_next[SRC_ALARM] = 1'b1;
                end
                CMD_FLAG:    pending_next[SRC_FLAG] = 1'b1;
                default:
                begin
                end
            endcase
        end
    end

    assign irq_new = |(pending_next & mask_next[4:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= WORD_RESET;
            cnt_b_reg     <= WORD_RESET;
            reload_a_reg  <= WORD_RESET;
            reload_b_reg  <= WORD_RESET;
            ctrl_a_reg    <= CTRL_RESET;
            ctrl_b_reg    <= CTRL_RESET;
            day_reg       <= 24'd0;
            alarm_reg     <= 24'd0;
            snap_reg      <= 24'd0;
            snap_held_reg <= 1'b0;
            running_reg   <= 1'b0;
            pending_reg   <= 5'd0;
            mask_reg      <= 7'd0;
            port_a_reg    <= PORT_A_RESET;
            port_b_reg    <= 8'd0;
            ddr_a_reg     <= 8'd0;
            ddr_b_reg     <= 8'd0;
            serial_reg    <= 8'd0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            reload_a_reg  <= reload_a_next;
            reload_b_reg  <= reload_b_next;
            ctrl_a_reg    <= ctrl_a_next;
            ctrl_b_reg    <= ctrl_b_next;
            day_reg       <= day_next;
            alarm_reg     <= alarm_next;
            snap_reg      <= snap_next;
            snap_held_reg <= snap_held_next;
            running_reg   <= running_next;
            pending_reg   <= pending_next;
            mask_reg      <= mask_next;
            port_a_reg    <= port_a_next;
            port_b_reg    <= port_b_next;
            ddr_a_reg     <= ddr_a_next;
            ddr_b_reg     <= ddr_b_next;
            serial_reg    <= serial_next;
        end
    end

    // output word plus skid word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
                out_irq_reg  <= skid_irq_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= rd_new;
                out_irq_reg  <= irq_new;
            end
            else
            begin
                skid_data_reg <= rd_new;
                skid_irq_reg  <= irq_new;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign irq       = out_irq_reg;

endmodule

FILE: rtl/core/ctiu_checker.sv
// ----------------------------------------------------------------------------
// ctiu_checker
// Port-level checks of the unit's output stage, bound to the top level.
// ----------------------------------------------------------------------------
module ctiu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_data,
    input logic       irq
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(irq))
        else $error("stalled output word changed");

    // the input side only stalls while the output register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // after an accepted word the output always holds a valid result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word produced no result");

    // skid fills only when a result was blocked downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
        else $error("stall raised without blocked output");

endmodule

bind cia_timer_tod_interrupt_unit_top ctiu_checker u_ctiu_checker (.*);
